@@ hw/rtl/iecu_pkg.sv @@
package iecu_pkg;

  localparam int IMM_BITS_DEF = 24;
  localparam int IMM_OUT_W    = 24;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] OP_IMM  = 8'd1;
  localparam logic [7:0] OP_PUSH = 8'd13;
  localparam logic [7:0] OP_ADD  = 8'd25;
  localparam logic [7:0] OP_SUB  = 8'd26;
  localparam logic [7:0] OP_MUL  = 8'd27;
  localparam logic [7:0] OP_DIV  = 8'd28;
  localparam logic [7:0] OP_HALT = 8'd38;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_MUL  = 8'd42;
  localparam logic [7:0] CH_ADD  = 8'd43;
  localparam logic [7:0] CH_SUB  = 8'd45;
  localparam logic [7:0] CH_DIV  = 8'd47;

  // word slots of one queued command, emitted lowest first
  localparam int W_IMM  = 0;
  localparam int W_PROD = 1;
  localparam int W_SUM  = 2;
  localparam int W_TAIL = 3;
  localparam int NUM_W  = 4;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_FIRST  = 2'd1,
    PEND_SECOND = 2'd2
  } pend_t;

  typedef struct packed {
    logic                 has_imm;
    logic [IMM_OUT_W-1:0] imm;
    logic                 ovf;
    pend_t                prod_op;
    pend_t                sum_op;
    logic                 tail_halt;
  } entry_t;

endpackage

@@ hw/rtl/iecu_front.sv @@
module iecu_front #(
  parameter int IMM_BITS = iecu_pkg::IMM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_char_code,
  output logic            in_ready,
  output logic            push,
  output iecu_pkg::entry_t push_data,
  input  logic            full
);
  import iecu_pkg::*;

  localparam int VW = IMM_BITS + 4;

  logic [IMM_BITS-1:0] acc_r;
  logic                in_number_r;
  logic                ovf_r;
  pend_t               prod_r;
  pend_t               sum_r;

  logic          accept;
  logic          is_digit;
  logic          is_prod;
  logic          is_sum;
  logic [VW-1:0] acc_ext;
  logic [VW-1:0] v;

  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_prod  = (in_char_code == CH_MUL) || (in_char_code == CH_DIV);
  assign is_sum   = (in_char_code == CH_ADD) || (in_char_code == CH_SUB);

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && !is_digit;

  // acc*10 + digit as shift-add
  assign acc_ext = VW'(acc_r);
  assign v = (acc_ext << 3) + (acc_ext << 1) + VW'(in_char_code[3:0]);

  always_comb begin
    push_data.has_imm   = in_number_r;
    push_data.imm       = IMM_OUT_W'(acc_r);
    push_data.ovf       = ovf_r;
    push_data.prod_op   = prod_r;
    push_data.sum_op    = is_prod ? PEND_NONE : sum_r;
    push_data.tail_halt = !is_prod && !is_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      in_number_r <= 1'b0;
      ovf_r       <= 1'b0;
      prod_r      <= PEND_NONE;
      sum_r       <= PEND_NONE;
    end else if (accept) begin
      if (is_digit) begin
        acc_r       <= v[IMM_BITS-1:0];
        in_number_r <= 1'b1;
        ovf_r       <= ovf_r || (v[VW-1:IMM_BITS] != '0);
      end else begin
        acc_r       <= '0;
        in_number_r <= 1'b0;
        ovf_r       <= 1'b0;
        if (is_prod) begin
          prod_r <= (in_char_code == CH_MUL) ? PEND_FIRST : PEND_SECOND;
        end else begin
          prod_r <= PEND_NONE;
          if (is_sum) begin
            sum_r <= (in_char_code == CH_ADD) ? PEND_FIRST : PEND_SECOND;
          end else begin
            sum_r <= PEND_NONE;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/iecu_fifo.sv @@
module iecu_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iecu_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output iecu_pkg::entry_t data
);
  import iecu_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

  entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign valid   = (cnt_r != '0);
  assign data    = mem[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST_P) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_P) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/iecu_back.sv @@
module iecu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  iecu_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_opcode,
  output logic [iecu_pkg::IMM_OUT_W-1:0] out_immediate,
  output logic             out_imm_overflow,
  output logic             out_last
);
  import iecu_pkg::*;

  entry_t             cur_r;
  logic [NUM_W-1:0]   mask_r;
  logic               out_valid_r;
  logic [7:0]         opc_r;
  logic [IMM_OUT_W-1:0] imm_r;
  logic               ovf_r;
  logic               last_r;

  logic                 advance;
  logic                 emit;
  logic [NUM_W-1:0]     clr;
  logic [NUM_W-1:0]     mask_after;
  logic [NUM_W-1:0]     load_mask;
  logic [7:0]           w_opc;
  logic [IMM_OUT_W-1:0] w_imm;
  logic                 w_ovf;
  logic                 w_last;

  assign advance    = !out_valid_r || out_ready;
  assign emit       = advance && (mask_r != '0);
  assign mask_after = emit ? (mask_r & ~clr) : mask_r;
  assign q_pop      = q_valid && (mask_after == '0);

  always_comb begin
    load_mask         = '0;
    load_mask[W_IMM]  = q_data.has_imm;
    load_mask[W_PROD] = (q_data.prod_op != PEND_NONE);
    load_mask[W_SUM]  = (q_data.sum_op != PEND_NONE);
    load_mask[W_TAIL] = 1'b1;
  end

  always_comb begin
    clr    = '0;
    w_opc  = OP_PUSH;
    w_imm  = '0;
    w_ovf  = 1'b0;
    w_last = 1'b0;
    if (mask_r[W_IMM]) begin
      clr[W_IMM] = 1'b1;
      w_opc      = OP_IMM;
      w_imm      = cur_r.imm;
      w_ovf      = cur_r.ovf;
    end else if (mask_r[W_PROD]) begin
      clr[W_PROD] = 1'b1;
      w_opc       = (cur_r.prod_op == PEND_FIRST) ? OP_MUL : OP_DIV;
    end else if (mask_r[W_SUM]) begin
      clr[W_SUM] = 1'b1;
      w_opc      = (cur_r.sum_op == PEND_FIRST) ? OP_ADD : OP_SUB;
    end else begin
      clr[W_TAIL] = 1'b1;
      w_opc       = cur_r.tail_halt ? OP_HALT : OP_PUSH;
      w_last      = cur_r.tail_halt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= q_pop ? load_mask : mask_after;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      opc_r  <= w_opc;
      imm_r  <= w_imm;
      ovf_r  <= w_ovf;
      last_r <= w_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_opcode       = opc_r;
  assign out_immediate    = imm_r;
  assign out_imm_overflow = ovf_r;
  assign out_last         = last_r;

endmodule

@@ hw/rtl/infix_expr_to_stack_code_unit.sv @@
// Compiles an infix expression, one ASCII character per input beat, into
// stack bytecode words, one per output beat. A digit beat is absorbed and
// produces nothing. Any other character produces one to four words (IMM,
// MUL/DIV, ADD/SUB, then PUSH or HALT with last set), which the output
// sequencer emits at one word per cycle while out_ready does not hold it back;
// the input is stalled only while the two-entry command queue between the
// parser and the sequencer is full. After HALT the block starts over on the
// next expression.
module infix_expr_to_stack_code_unit #(
  parameter int IMM_BITS = iecu_pkg::IMM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_opcode,
  output logic [iecu_pkg::IMM_OUT_W-1:0] out_immediate,
  output logic       out_imm_overflow,
  output logic       out_last
);
  import iecu_pkg::*;

  logic   push;
  entry_t push_data;
  logic   full;
  logic   q_valid;
  entry_t q_data;
  logic   q_pop;

  iecu_front #(
    .IMM_BITS(IMM_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_ready    (in_ready),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  iecu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .data     (q_data)
  );

  iecu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_opcode      (out_opcode),
    .out_immediate   (out_immediate),
    .out_imm_overflow(out_imm_overflow),
    .out_last        (out_last)
  );

endmodule

@@ hw/rtl/iecu_checker.sv @@
module iecu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_opcode,
  input logic [iecu_pkg::IMM_OUT_W-1:0] out_immediate,
  input logic       out_imm_overflow,
  input logic       out_last
);
  import iecu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_opcode)
      && $stable(out_immediate) && $stable(out_imm_overflow) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_last_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_opcode == OP_HALT)))
    else $error("last does not match HALT");

  a_imm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_opcode != OP_IMM) |-> (out_immediate == '0) && !out_imm_overflow)
    else $error("immediate fields set on non-IMM word");

  a_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_opcode == OP_IMM) || (out_opcode == OP_PUSH)
      || (out_opcode == OP_ADD) || (out_opcode == OP_SUB) || (out_opcode == OP_MUL)
      || (out_opcode == OP_DIV) || (out_opcode == OP_HALT))
    else $error("unknown opcode");

endmodule

bind infix_expr_to_stack_code_unit iecu_checker u_iecu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_opcode      (out_opcode),
  .out_immediate   (out_immediate),
  .out_imm_overflow(out_imm_overflow),
  .out_last        (out_last)
);

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iecu_pkg::*;

  localparam int ACC_W        = IMM_BITS_DEF;
  localparam int ITEMS        = 480;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [7:0]           opcode;
    logic [IMM_OUT_W-1:0] immediate;
    logic                 imm_overflow;
    logic                 last;
  } code_word_t;

  class code_scoreboard;
    logic [ACC_W-1:0] acc;
    logic             in_num;
    logic             acc_wrapped;
    pend_t            prod_op;
    pend_t            sum_op;
    code_word_t       expected_words[$];
    int               errors;
    int               words_checked;

    function new();
      clear_expr();
      errors = 0;
      words_checked = 0;
    endfunction

    function void clear_expr();
      acc = '0;
      in_num = 1'b0;
      acc_wrapped = 1'b0;
      prod_op = PEND_NONE;
      sum_op = PEND_NONE;
    endfunction

    function void add_word(logic [7:0] op, logic [IMM_OUT_W-1:0] imm, logic ovf, logic last);
      code_word_t w;
      w.opcode = op;
      w.immediate = imm;
      w.imm_overflow = ovf;
      w.last = last;
      expected_words.push_back(w);
    endfunction

    // accepted input beat: compile one character into the expected words
    function void note_char(logic [7:0] c);
      logic [ACC_W+3:0] next_acc;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        next_acc = (ACC_W+4)'(acc * 10 + (c - CH_ZERO));
        if (next_acc[ACC_W+3:ACC_W] != '0) acc_wrapped = 1'b1;
        acc = next_acc[ACC_W-1:0];
        in_num = 1'b1;
        return;
      end
      if (in_num) begin
        add_word(OP_IMM, IMM_OUT_W'(acc), acc_wrapped, 1'b0);
        acc = '0;
        in_num = 1'b0;
        acc_wrapped = 1'b0;
      end
      if (prod_op != PEND_NONE) begin
        add_word((prod_op == PEND_FIRST) ? OP_MUL : OP_DIV, '0, 1'b0, 1'b0);
        prod_op = PEND_NONE;
      end
      if (c == CH_MUL || c == CH_DIV) begin
        add_word(OP_PUSH, '0, 1'b0, 1'b0);
        prod_op = (c == CH_MUL) ? PEND_FIRST : PEND_SECOND;
        return;
      end
      if (sum_op != PEND_NONE) begin
        add_word((sum_op == PEND_FIRST) ? OP_ADD : OP_SUB, '0, 1'b0, 1'b0);
        sum_op = PEND_NONE;
      end
      if (c == CH_ADD || c == CH_SUB) begin
        add_word(OP_PUSH, '0, 1'b0, 1'b0);
        sum_op = (c == CH_ADD) ? PEND_FIRST : PEND_SECOND;
        return;
      end
      add_word(OP_HALT, '0, 1'b0, 1'b1);
      clear_expr();
    endfunction

    // accepted output beat: compare against the oldest expected word
    function void check_word(logic [7:0] op, logic [IMM_OUT_W-1:0] imm, logic ovf,
                             logic last);
      code_word_t w;
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: opcode %0d", op);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (op !== w.opcode) begin
        $error("opcode: expected %0d, got %0d", w.opcode, op);
        errors++;
      end
      if (imm !== w.immediate) begin
        $error("immediate: expected %0d, got %0d", w.immediate, imm);
        errors++;
      end
      if (ovf !== w.imm_overflow) begin
        $error("imm_overflow: expected %0d, got %0d", w.imm_overflow, ovf);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_char_code;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_opcode;
  logic [IMM_OUT_W-1:0] out_immediate;
  logic                 out_imm_overflow;
  logic                 out_last;

  code_scoreboard sb;
  int             cycles = 0;
  int             sent_items = 0;
  bit             send_burst;
  logic [7:0]     op_chars[4] = '{CH_MUL, CH_DIV, CH_ADD, CH_SUB};

  infix_expr_to_stack_code_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_opcode       (out_opcode),
    .out_immediate    (out_immediate),
    .out_imm_overflow (out_imm_overflow),
    .out_last         (out_last)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("infix_expr_to_stack_code_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_char(in_char_code);
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_opcode, out_immediate, out_imm_overflow, out_last);
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
  endtask

  // output side; one long hold-off to back the block up into its input
  initial begin : sink
    int gap;
    bit burst;
    bit held;
    burst = 1'b0;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if (!held && sb.words_checked >= HOLD_AT_WORD) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stim
    string      dir_text;
    int         n_atoms;
    int         n_dig;
    logic [7:0] term;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    send_burst = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty expression, max immediate, empty atoms, wrapped number
    send_char(8'hFF);
    dir_text = "16777215*/-+99999999";
    for (int i = 0; i < dir_text.len(); i++) send_char(dir_text[i]);
    send_char(8'h00);

    while (sent_items < ITEMS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      end else begin
        n_atoms = $urandom_range(1, 6);
        for (int a = 0; a < n_atoms; a++) begin
          if (a > 0) send_char(op_chars[$urandom_range(0, 3)]);
          if ($urandom_range(0, 7) != 0) begin
            n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 3);
            repeat (n_dig) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
        do begin
          term = 8'($urandom_range(0, 255));
        end while ((term >= CH_ZERO && term <= CH_NINE) ||
                   (term inside {CH_MUL, CH_DIV, CH_ADD, CH_SUB}));
        send_char(term);
      end
    end
    send_char(8'h3B);
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (out_valid) begin
      $error("unexpected word left at output: opcode %0d", out_opcode);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("infix_expr_to_stack_code_unit: match");
    end else begin
      $display("infix_expr_to_stack_code_unit: mismatch");
    end
    $finish;
  end

endmodule
